// ----- sv/msa_pkg.sv -----
// ----------------------------------------------------------------------------
// msa_pkg: shared types and constants for the max-distance seat allocator
// Holds the sequencer state type, the scan unit control bundle and the field
// widths of the request and result ports.
// ----------------------------------------------------------------------------
package msa_pkg;

    localparam int NUM_SEATS_DEF = 64;

    localparam int CFG_W   = 7;
    localparam int REL_W   = 6;
    localparam int TAKEN_W = 6;

    localparam logic [CFG_W-1:0] ACTIVE_SEATS_RST = CFG_W'(64);

    localparam logic CMD_TAKE    = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic clr;     // start a new take
        logic step;    // one occupancy bit arrives
        logic occ;     // its value
        logic finish;  // close the row at the effective count
    } t_gap_ctl;

endpackage

// ----- sv/msa_ram.sv -----
// ----------------------------------------------------------------------------
// msa_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module msa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/msa_gap_unit.sv -----
// ----------------------------------------------------------------------------
// msa_gap_unit: shared gap scoring unit
// Takes occupancy bits in seat order, scores each gap between occupied seats
// and the two row ends, and keeps the best seat, lowest index on ties.
// ----------------------------------------------------------------------------
module msa_gap_unit
    import msa_pkg::*;
#(
    parameter int NUM_SEATS = NUM_SEATS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  t_gap_ctl                         i_ctl,
    input  logic [$clog2(NUM_SEATS)-1:0]     i_seat,
    input  logic [$clog2(NUM_SEATS+1)-1:0]   i_count,
    output logic [$clog2(NUM_SEATS)-1:0]     o_best_idx,
    output logic                             o_found
);

    localparam int IDX_W = $clog2(NUM_SEATS);

    logic [IDX_W-1:0] r_best_s, n_best_s;
    logic [IDX_W-1:0] r_best_idx, n_best_idx;
    logic [IDX_W-1:0] r_prev, n_prev;
    logic             r_seen, n_seen;
    logic             r_lone, n_lone;

    logic [IDX_W-1:0] last;
    logic [IDX_W-1:0] cand_s;
    logic [IDX_W-1:0] cand_idx;
    logic             cand_v;

    assign last = IDX_W'(i_count - 1'b1);

    // One candidate per cycle: left edge, midpoint of a gap, or right edge.
    always_comb begin
        cand_s   = '0;
        cand_idx = '0;
        cand_v   = 1'b0;
        if (i_ctl.step && i_ctl.occ) begin
            cand_v = 1'b1;
            if (!r_seen) begin
                cand_s = i_seat;
            end else begin
                cand_s   = (i_seat - r_prev) >> 1;
                cand_idx = r_prev + ((i_seat - r_prev) >> 1);
            end
        end else if (i_ctl.finish && r_seen) begin
            cand_v   = 1'b1;
            cand_s   = last - r_prev;
            cand_idx = last;
        end
    end

    always_comb begin
        n_best_s   = r_best_s;
        n_best_idx = r_best_idx;
        n_prev     = r_prev;
        n_seen     = r_seen;
        n_lone     = r_lone;
        if (i_ctl.clr) begin
            n_best_s   = '0;
            n_best_idx = '0;
            n_seen     = 1'b0;
            n_lone     = 1'b0;
        end else begin
            // Strict compare keeps the lowest index on a tie.
            if (cand_v && (cand_s > r_best_s)) begin
                n_best_s   = cand_s;
                n_best_idx = cand_idx;
            end
            if (i_ctl.step && i_ctl.occ) begin
                n_prev = i_seat;
                n_seen = 1'b1;
            end
            // Empty row: seat 0 is farthest from the far end.
            if (i_ctl.finish && !r_seen) begin
                if (i_count >= 2) begin
                    n_best_s   = last;
                    n_best_idx = '0;
                end else if (i_count == 1) begin
                    n_lone = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_s <= '0;
            r_seen   <= 1'b0;
            r_lone   <= 1'b0;
        end else begin
            r_best_s <= n_best_s;
            r_seen   <= n_seen;
            r_lone   <= n_lone;
        end
        r_best_idx <= n_best_idx;
        r_prev     <= n_prev;
    end

    assign o_best_idx = r_best_idx;
    assign o_found    = (r_best_s != '0) || r_lone;

endmodule

// ----- sv/max_distance_seat_allocator.sv -----
// ----------------------------------------------------------------------------
// max_distance_seat_allocator: seat allocator that maximizes distance
// Take: the sequencer sweeps the occupancy row in SCAN, then passes DRAIN, FINISH and
// COMMIT, where the result is strobed; an empty row (effective count 0) skips SCAN; busy drops after strobe.
// Release: no result, back to back. The receiver cannot stall.
// Reset (synchronous, active low) runs a clearing pass over every word of the
// occupancy RAM with busy high; the seat count returns to 64.
// ----------------------------------------------------------------------------
module max_distance_seat_allocator
    import msa_pkg::*;
#(
    parameter int NUM_SEATS = NUM_SEATS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cmd,
    input  logic [REL_W-1:0]   i_release_index,
    input  logic               i_cfg_we,
    input  logic [CFG_W-1:0]   i_cfg_wdata,
    output logic               o_result_valid,
    output logic [TAKEN_W-1:0] o_taken_index,
    output logic               o_full_res
);

    localparam int IDX_W = $clog2(NUM_SEATS);
    localparam int CNT_W = $clog2(NUM_SEATS + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int REL_CMP_W = (CNT_W > REL_W) ? CNT_W : REL_W;

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_active_seats;
    logic [CNT_W-1:0] r_n, n_n;
    logic [CNT_W-1:0] r_addr, n_addr;
    logic             r_rd_v;
    logic [IDX_W-1:0] r_rd_idx;

    logic             accept;
    logic             take_req;
    logic             rel_ok;
    logic [CNT_W-1:0] eff_count;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic             ram_wdata;
    logic             ram_re;
    logic             ram_rdata;

    t_gap_ctl         gap_ctl;
    logic [IDX_W-1:0] best_idx;
    logic             found;

    assign accept   = start && !busy;
    assign take_req = accept && (i_cmd == CMD_TAKE);

    // Saturate the configured count at the row size.
    assign eff_count = (CMP_W'(r_active_seats) > CMP_W'(NUM_SEATS)) ?
                       CNT_W'(NUM_SEATS) : CNT_W'(r_active_seats);

    // Drop releases beyond the row.
    assign rel_ok = REL_CMP_W'(i_release_index) < REL_CMP_W'(NUM_SEATS);

    // Configuration register: written whenever the enable is high.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_seats <= ACTIVE_SEATS_RST;
        end else if (i_cfg_we) begin
            r_active_seats <= i_cfg_wdata;
        end
    end

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        n_n     = r_n;
        unique case (r_state)
            S_CLEAR: begin
                n_addr = r_addr + 1'b1;
                if (r_addr == CNT_W'(NUM_SEATS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (take_req) begin
                    n_n    = eff_count;
                    n_addr = '0;
                    // Nothing to sweep in an empty row: go close it.
                    n_state = (eff_count == '0) ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN: begin
                n_addr = r_addr + 1'b1;
                if (r_addr == r_n - 1'b1) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN:  n_state = S_FINISH;
            S_FINISH: n_state = S_COMMIT;
            S_COMMIT: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
            r_rd_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_rd_v  <= (r_state == S_SCAN);
        end
        r_n      <= n_n;
        r_rd_idx <= IDX_W'(r_addr);
    end

    // Output and datapath control of the sequencer.
    always_comb begin
        busy      = 1'b1;
        ram_we    = 1'b0;
        ram_waddr = IDX_W'(r_addr);
        ram_wdata = 1'b0;
        ram_re    = 1'b0;
        gap_ctl   = '0;
        o_result_valid = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
            end
            S_IDLE: begin
                busy        = 1'b0;
                gap_ctl.clr = take_req;
                // A release clears its seat in the accept cycle.
                if (accept && (i_cmd == CMD_RELEASE) && rel_ok) begin
                    ram_we    = 1'b1;
                    ram_waddr = IDX_W'(i_release_index);
                end
            end
            S_SCAN: begin
                ram_re = 1'b1;
            end
            S_DRAIN: ;
            S_FINISH: begin
                gap_ctl.finish = 1'b1;
            end
            S_COMMIT: begin
                o_result_valid = 1'b1;
                // Mark the winner taken; hold the row when it is full.
                ram_we    = found;
                ram_waddr = best_idx;
                ram_wdata = 1'b1;
            end
            default: ;
        endcase
        // Read data is registered and arrives in the cycle after its address, like r_rd_v.
        gap_ctl.step = r_rd_v;
        gap_ctl.occ  = ram_rdata;
    end

    assign o_taken_index = found ? TAKEN_W'(best_idx) : '0;
    assign o_full_res    = !found;

    msa_ram #(
        .WIDTH (1),
        .DEPTH (NUM_SEATS)
    ) u_occ_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (IDX_W'(r_addr)),
        .o_rdata (ram_rdata)
    );

    msa_gap_unit #(
        .NUM_SEATS (NUM_SEATS)
    ) u_gap_unit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (gap_ctl),
        .i_seat     (r_rd_idx),
        .i_count    (r_n),
        .o_best_idx (best_idx),
        .o_found    (found)
    );

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for the max-distance seat allocator
// Drives take and release requests through the start/busy handshake and keeps
// its own copy of the occupancy row and seat count. Each take is scored there
// and the expected seat or full flag is queued. The monitor compares every
// strobed result with the oldest queued grant. The seat count is changed
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
    import msa_pkg::*;

    localparam int RUN_LIMIT = 1_000_000;   // cycles before the run is aborted
    localparam int NUM_PHASES = 10;

    typedef struct {
        logic             cmd;
        logic [REL_W-1:0] idx;
    } t_seat_req;

    typedef struct {
        logic [TAKEN_W-1:0] idx;
        logic               full;
    } t_seat_grant;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_cmd = CMD_TAKE;
    logic [REL_W-1:0]   i_release_index = '0;
    logic               i_cfg_we = 1'b0;
    logic [CFG_W-1:0]   i_cfg_wdata = '0;
    logic               o_result_valid;
    logic [TAKEN_W-1:0] o_taken_index;
    logic               o_full_res;

    // Requests waiting to be driven, grants waiting to be strobed.
    t_seat_req   pending_reqs[$];
    t_seat_grant grants_due[$];

    // Shadow of the block state.
    logic [NUM_SEATS_DEF-1:0] seat_map;
    logic [CFG_W-1:0]         seat_count;

    int  idle_pct = 0;   // chance in 100 that the sender leaves a cycle empty
    bit  req_taken = 1'b0;
    int  err_cnt = 0;
    int  cycle_cnt = 0;

    max_distance_seat_allocator uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .i_release_index (i_release_index),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_result_valid  (o_result_valid),
        .o_taken_index   (o_taken_index),
        .o_full_res      (o_full_res)
    );

    always #1 i_clk = ~i_clk;

    // Score every empty seat inside the active count by its distance to the
    // nearest occupied seat; the row ends are not walls, and an empty row
    // scores by the farther end. Take the best seat, lowest index on a tie.
    function automatic t_seat_grant pick_seat();
        int n;
        int i;
        int j;
        int lo;
        int hi;
        int d;
        int best;
        int best_d;
        t_seat_grant g;
        n = (int'(seat_count) > NUM_SEATS_DEF) ? NUM_SEATS_DEF : int'(seat_count);
        best = -1;
        best_d = 0;
        if (n == 1) begin
            if (!seat_map[0]) best = 0;
        end else if (n >= 2) begin
            for (i = 0; i < n; i++) begin
                if (seat_map[i]) continue;
                lo = -1;
                hi = -1;
                for (j = i - 1; j >= 0; j--) begin
                    if (seat_map[j]) begin
                        lo = j;
                        break;
                    end
                end
                for (j = i + 1; j < n; j++) begin
                    if (seat_map[j]) begin
                        hi = j;
                        break;
                    end
                end
                if (lo >= 0 && hi >= 0) d = ((i - lo) < (hi - i)) ? (i - lo) : (hi - i);
                else if (lo >= 0)       d = i - lo;
                else if (hi >= 0)       d = hi - i;
                else                    d = (i > n - 1 - i) ? i : (n - 1 - i);
                if (d > best_d) begin
                    best_d = d;
                    best = i;
                end
            end
        end
        if (best >= 0) begin
            seat_map[best] = 1'b1;
            g.idx = TAKEN_W'(best);
            g.full = 1'b0;
        end else begin
            g.idx = '0;
            g.full = 1'b1;
        end
        return g;
    endfunction

    // Monitor: track accepted requests and config writes at the rising edge,
    // and check each strobed result against the oldest queued grant.
    always @(posedge i_clk) begin
        t_seat_grant g;
        if (!i_rst_n) begin
            seat_map <= '0;
            seat_count <= ACTIVE_SEATS_RST;
            req_taken = 1'b0;
        end else begin
            req_taken = start && !busy;
            if (i_cfg_we) seat_count <= i_cfg_wdata;
            if (req_taken) begin
                if (i_cmd == CMD_RELEASE) seat_map[i_release_index] = 1'b0;
                else grants_due.push_back(pick_seat());
            end
            if (o_result_valid) begin
                if (grants_due.size() == 0) begin
                    $error("unexpected result: taken_index %0d full_res %0d",
                           o_taken_index, o_full_res);
                    err_cnt++;
                end else begin
                    g = grants_due.pop_front();
                    if (o_taken_index !== g.idx) begin
                        $error("taken_index: expected %0d, got %0d", g.idx, o_taken_index);
                        err_cnt++;
                    end
                    if (o_full_res !== g.full) begin
                        $error("full_res: expected %0d, got %0d", g.full, o_full_res);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // Driver: at the falling edge, hold the current request until it is
    // taken, then present the next one or leave a gap.
    always @(negedge i_clk) begin
        t_seat_req r;
        if (!start || req_taken) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
                r = pending_reqs.pop_front();
                i_cmd <= r.cmd;
                i_release_index <= r.idx;
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= RUN_LIMIT) begin
            $display("[max_distance_seat_allocator] ERROR");
            $finish;
        end
    end

    task automatic push_req(input logic cmd, input int idx);
        t_seat_req r;
        r.cmd = cmd;
        r.idx = REL_W'(idx);
        pending_reqs.push_back(r);
    endtask

    // Wait until every request is in and every grant has come out, then let
    // a trailing release finish.
    task automatic settle();
        while (pending_reqs.size() != 0 || start || grants_due.size() != 0 || busy !== 1'b0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_seat_count(input int v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= CFG_W'(v);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly takes so the row fills and reports full at times; releases land
    // mostly inside the active count, the rest anywhere in the row.
    task automatic push_random(input int count, input int cnt_cfg);
        int k;
        int n;
        logic cmd;
        int idx;
        n = (cnt_cfg > NUM_SEATS_DEF) ? NUM_SEATS_DEF : cnt_cfg;
        for (k = 0; k < count; k++) begin
            cmd = ($urandom_range(99) < 62) ? CMD_TAKE : CMD_RELEASE;
            if (n == 0 || $urandom_range(3) == 0) idx = $urandom_range(NUM_SEATS_DEF - 1);
            else                                  idx = $urandom_range(n - 1);
            push_req(cmd, idx);
        end
    endtask

    initial begin
        int cfg_plan[NUM_PHASES];
        int size_plan[NUM_PHASES];
        int p;
        cfg_plan  = '{64, 127, 2, 1, 0, 64, 0, 0, 100, 64};
        size_plan = '{200, 180, 150, 60, 40, 200, 180, 180, 160, 200};
        cfg_plan[6] = $urandom_range(3, 63);
        cfg_plan[7] = $urandom_range(3, 63);

        // Hold reset, then wait out the clearing pass.
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        settle();

        // Full row: empty row goes to the lowest end, then the far end, then
        // the middle; release an empty seat twice.
        set_seat_count(64);
        push_req(CMD_TAKE, 63);
        push_req(CMD_TAKE, 0);
        push_req(CMD_TAKE, 21);
        push_req(CMD_RELEASE, 0);
        push_req(CMD_TAKE, 0);
        push_req(CMD_RELEASE, 63);
        push_req(CMD_RELEASE, 63);
        push_req(CMD_TAKE, 42);
        push_req(CMD_RELEASE, 5);
        settle();

        // Short row: seats above the count stay set but are ignored; fill it
        // up, report full, release a seat beyond the count.
        set_seat_count(3);
        push_req(CMD_TAKE, 0);
        push_req(CMD_TAKE, 1);
        push_req(CMD_TAKE, 2);
        push_req(CMD_TAKE, 3);
        push_req(CMD_RELEASE, 40);
        push_req(CMD_TAKE, 63);
        settle();

        // One-seat row.
        set_seat_count(1);
        push_req(CMD_TAKE, 0);
        push_req(CMD_RELEASE, 0);
        push_req(CMD_TAKE, 0);
        push_req(CMD_TAKE, 0);
        settle();

        // No seats at all, then a count above the row size.
        set_seat_count(0);
        push_req(CMD_TAKE, 7);
        push_req(CMD_RELEASE, 1);
        push_req(CMD_TAKE, 0);
        settle();
        set_seat_count(127);
        push_req(CMD_TAKE, 0);
        settle();

        // Random phases; each ends with the sender paused until all grants
        // have come out, then the seat count moves.
        for (p = 0; p < NUM_PHASES; p++) begin
            set_seat_count(cfg_plan[p]);
            case (p % 3)
                0: begin
                    idle_pct = 0;
                end
                1: begin
                    idle_pct = 71;
                end
                default: begin
                    idle_pct = 15;
                end
            endcase
            push_random(size_plan[p], cfg_plan[p]);
            settle();
        end

        // Catch stray results after the last grant.
        repeat (80) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("[max_distance_seat_allocator] OK");
        end else begin
            $display("[max_distance_seat_allocator] ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/msa_pkg.sv
sv/msa_ram.sv
sv/msa_gap_unit.sv
sv/max_distance_seat_allocator.sv
tb/tb.sv
